// ===== rtl/pulse_interval_remote_decoder_top_assert.svh =====
// assertion macros for the pulse interval remote decoder
`ifndef PULSE_INTERVAL_REMOTE_DECODER_TOP_ASSERT_SVH
`define PULSE_INTERVAL_REMOTE_DECODER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PIRD_CHECK(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pird check failed");

// next-cycle implication, sampled on clk, off during reset
`define PIRD_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pird next-cycle check failed");

`endif

// ===== rtl/pird_pkg.sv =====
// shared types and constants of the pulse interval remote decoder
package pird_pkg;

    // opcodes
    localparam logic [1:0] OP_EDGE = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_ACK  = 2'd2;
    localparam logic [1:0] OP_READ = 2'd3;

    // pulse classes
    localparam logic [2:0] CLS_TOO_SHORT = 3'd0;
    localparam logic [2:0] CLS_SHORT     = 3'd1;
    localparam logic [2:0] CLS_LONG      = 3'd2;
    localparam logic [2:0] CLS_GAP       = 3'd3;
    localparam logic [2:0] CLS_TIMEOUT   = 3'd4;
    localparam logic [2:0] CLS_NONE      = 3'd5;

    // register indexes
    localparam logic [2:0] REG_SHORT_MIN    = 3'd0;
    localparam logic [2:0] REG_SHORT_MAX    = 3'd1;
    localparam logic [2:0] REG_LONG_MIN     = 3'd2;
    localparam logic [2:0] REG_LONG_MAX     = 3'd3;
    localparam logic [2:0] REG_PREAMBLE_MIN = 3'd4;
    localparam logic [2:0] REG_MESSAGE_LEN  = 3'd5;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // address width for the largest supported buffer (up to 127 bytes plus terminator)
    localparam int MEM_AW_MAX = 7;

    localparam logic [6:0] SAT_LIMIT = 7'd100;

    typedef struct packed {
        logic [15:0] short_min;
        logic [15:0] short_max;
        logic [15:0] long_min;
        logic [15:0] long_max;
        logic [6:0]  preamble_min;
        logic [3:0]  message_len;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        short_min:    16'd100,
        short_max:    16'd600,
        long_min:     16'd800,
        long_max:     16'd2000,
        preamble_min: 7'd10,
        message_len:  4'd4
    };

    typedef struct packed {
        logic                  wr_en;
        logic [MEM_AW_MAX-1:0] wr_addr;
        logic [7:0]            wr_data;
        logic                  clr_en;
        logic [MEM_AW_MAX-1:0] clr_addr;
        logic                  rd_en;
        logic [MEM_AW_MAX-1:0] rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic [2:0] pulse_class;
        logic       byte_done;
        logic [7:0] byte_value;
        logic [2:0] byte_position;
        logic       message_done;
        logic       complete_now;
        logic       locked_now;
    } res_t;

endpackage

// ===== rtl/pird_if.sv =====
// event and result channel interfaces of the pulse interval remote decoder
interface pird_evt_if #(
    parameter int TIME_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           opcode;
    logic [TIME_BITS-1:0] capture_time;
    logic [3:0]           read_index;

    modport source (output valid, output opcode, output capture_time, output read_index,
                    input ready);
    modport sink (input valid, input opcode, input capture_time, input read_index,
                  output ready);
endinterface

interface pird_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] pulse_class;
    logic       byte_done;
    logic [7:0] byte_value;
    logic [2:0] byte_position;
    logic       message_done;
    logic       complete_now;
    logic       locked_now;
    logic [7:0] read_data;

    modport source (output valid, output pulse_class, output byte_done, output byte_value,
                    output byte_position, output message_done, output complete_now,
                    output locked_now, output read_data, input ready);
    modport sink (input valid, input pulse_class, input byte_done, input byte_value,
                  input byte_position, input message_done, input complete_now,
                  input locked_now, input read_data, output ready);
endinterface

// ===== rtl/pulse_interval_remote_decoder_top.sv =====
// top level of the pulse interval remote decoder
//
// evt carries one item per transfer: an opcode with a capture timestamp
// (edge), a timeout tick, an acknowledge of a finished message, or a read
// of one message buffer byte. res returns exactly one result per item.
// configuration goes through the apb port, registers at byte address 4*i;
// the user writes them only while no item is in flight, the block does not enforce it.
// the result of an item is registered and valid in the cycle after its transfer.
// throughput: one item per cycle while res.ready is high; classification,
// framing update and the buffer write all happen in the cycle of the
// transfer, and the buffer read port returns its byte in the result register cycle.
// a held result does not block the next transfer when res.ready is high in
// the same cycle; with res.ready low the result register holds its value
// and evt.ready drops until it is taken.
// reset clears the framing state, the timers, the complete flag, the
// configuration to its defaults and every buffer valid bit, so the whole
// buffer reads zero; there is no clearing sweep.
`include "pulse_interval_remote_decoder_top_assert.svh"

module pulse_interval_remote_decoder_top #(
    parameter int BUF_BYTES = 8,
    parameter int TIME_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    pird_evt_if.sink                    evt,
    pird_res_if.source                  res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pird_pkg::APB_AW-1:0] paddr,
    input  logic [pird_pkg::APB_DW-1:0] pwdata,
    output logic [pird_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    pird_pkg::cfg_t     cfg;
    pird_pkg::mem_req_t mem_req;
    pird_pkg::res_t     result;
    logic [7:0]         rd_byte;
    logic               take;
    logic               out_valid_reg;

    assign evt.ready = !out_valid_reg || res.ready;
    assign take      = evt.valid && evt.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    pird_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pird_core #(
        .BUF_BYTES (BUF_BYTES),
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .opcode       (evt.opcode),
        .capture_time (evt.capture_time),
        .read_index   (evt.read_index),
        .cfg          (cfg),
        .mem_req      (mem_req),
        .result       (result)
    );

    pird_store #(
        .BUF_BYTES (BUF_BYTES)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .req     (mem_req),
        .rd_byte (rd_byte)
    );

    assign res.valid         = out_valid_reg;
    assign res.pulse_class   = result.pulse_class;
    assign res.byte_done     = result.byte_done;
    assign res.byte_value    = result.byte_value;
    assign res.byte_position = result.byte_position;
    assign res.message_done  = result.message_done;
    assign res.complete_now  = result.complete_now;
    assign res.locked_now    = result.locked_now;
    assign res.read_data     = rd_byte;

    `PIRD_CHECK(a_byte_needs_lock, res.valid && res.byte_done, res.locked_now)
    `PIRD_CHECK(a_msg_done_flags, res.valid && res.message_done,
        res.byte_done && res.complete_now)
    `PIRD_CHECK(a_read_only_on_read, res.valid && res.read_data != 8'd0,
        res.pulse_class == pird_pkg::CLS_NONE)
    `PIRD_CHECK_NEXT(a_ack_clears_flag, take && evt.opcode == pird_pkg::OP_ACK,
        res.valid && !res.complete_now)

endmodule

// ===== rtl/pird_cfg.sv =====
// apb configuration registers of the pulse interval remote decoder
module pird_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pird_pkg::APB_AW-1:0]   paddr,
    input  logic [pird_pkg::APB_DW-1:0]   pwdata,
    output logic [pird_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output pird_pkg::cfg_t                cfg
);

    pird_pkg::cfg_t cfg_reg;
    logic [2:0]     reg_idx;
    logic           wr_stb;

    assign reg_idx = paddr[4:2];
    assign wr_stb  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= pird_pkg::CFG_RESET;
        end
        else if (wr_stb)
        begin
            unique case (reg_idx)
                pird_pkg::REG_SHORT_MIN:    cfg_reg.short_min    <= pwdata[15:0];
                pird_pkg::REG_SHORT_MAX:    cfg_reg.short_max    <= pwdata[15:0];
                pird_pkg::REG_LONG_MIN:     cfg_reg.long_min     <= pwdata[15:0];
                pird_pkg::REG_LONG_MAX:     cfg_reg.long_max     <= pwdata[15:0];
                pird_pkg::REG_PREAMBLE_MIN: cfg_reg.preamble_min <= pwdata[6:0];
                pird_pkg::REG_MESSAGE_LEN:  cfg_reg.message_len  <= pwdata[3:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            pird_pkg::REG_SHORT_MIN:    prdata = 32'(cfg_reg.short_min);
            pird_pkg::REG_SHORT_MAX:    prdata = 32'(cfg_reg.short_max);
            pird_pkg::REG_LONG_MIN:     prdata = 32'(cfg_reg.long_min);
            pird_pkg::REG_LONG_MAX:     prdata = 32'(cfg_reg.long_max);
            pird_pkg::REG_PREAMBLE_MIN: prdata = 32'(cfg_reg.preamble_min);
            pird_pkg::REG_MESSAGE_LEN:  prdata = 32'(cfg_reg.message_len);
            default:                    prdata = '0;
        endcase
    end

endmodule

// ===== rtl/pird_store.sv =====
// message buffer memory with per-entry valid bits
module pird_store #(
    parameter int BUF_BYTES = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  pird_pkg::mem_req_t req,
    output logic [7:0]         rd_byte
);

    localparam int DEPTH = BUF_BYTES + 1;
    localparam int AW    = $clog2(DEPTH);

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [7:0]       rd_data_reg;
    logic             rd_ok_reg;
    logic [AW-1:0]    wa;
    logic [AW-1:0]    ca;
    logic [AW-1:0]    ra;

    assign wa = req.wr_addr[AW-1:0];
    assign ca = req.clr_addr[AW-1:0];
    assign ra = req.rd_addr[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (take && req.wr_en)
        begin
            mem[wa] <= req.wr_data;
        end
        if (take && req.rd_en)
        begin
            rd_data_reg <= mem[ra];
        end
    end

    // an entry that is not valid reads as zero (reset value and terminator)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else if (take)
        begin
            if (req.wr_en)
            begin
                valid_reg[wa] <= 1'b1;
            end
            if (req.clr_en)
            begin
                valid_reg[ca] <= 1'b0;
            end
            rd_ok_reg <= req.rd_en && valid_reg[ra];
        end
    end

    assign rd_byte = rd_ok_reg ? rd_data_reg : 8'd0;

endmodule

// ===== rtl/pird_core.sv =====
// interval classification, framing state and result register
module pird_core #(
    parameter int BUF_BYTES = 8,
    parameter int TIME_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic [1:0]           opcode,
    input  logic [TIME_BITS-1:0] capture_time,
    input  logic [3:0]           read_index,
    input  pird_pkg::cfg_t       cfg,
    output pird_pkg::mem_req_t   mem_req,
    output pird_pkg::res_t       result
);

    localparam int CW = $clog2(BUF_BYTES + 1);
    localparam int KW = (CW > 4) ? CW : 4;
    localparam int WW = (TIME_BITS > 16) ? TIME_BITS : 16;

    logic [TIME_BITS-1:0] last_reg, last_next;
    logic [6:0]           tick_reg, tick_next;
    logic                 lock_reg, lock_next;
    logic [6:0]           ones_reg, ones_next;
    logic [2:0]           bit_reg, bit_next;
    logic [CW-1:0]        byte_reg, byte_next;
    logic [7:0]           shift_reg, shift_next;
    logic                 cf_reg, cf_next;
    pird_pkg::res_t       res_reg, res_next;

    logic [TIME_BITS-1:0] iv;
    logic [WW-1:0]        ivw;
    logic                 shift_en;
    logic                 shift_bit;
    logic [CW-1:0]        byte_cur;
    logic [CW-1:0]        byte_inc;
    logic [KW-1:0]        idx_w;

    assign iv    = capture_time - last_reg;
    assign ivw   = WW'(iv);
    assign idx_w = KW'(read_index);

    always_comb
    begin
        last_next  = last_reg;
        tick_next  = tick_reg;
        lock_next  = lock_reg;
        ones_next  = ones_reg;
        bit_next   = bit_reg;
        byte_next  = byte_reg;
        shift_next = shift_reg;
        cf_next    = cf_reg;
        shift_en   = 1'b0;
        shift_bit  = 1'b0;
        byte_cur   = '0;
        byte_inc   = '0;
        mem_req    = '0;
        res_next   = '0;
        res_next.pulse_class = pird_pkg::CLS_NONE;

        unique case (opcode)
            pird_pkg::OP_EDGE:
            begin
                last_next = capture_time;
                tick_next = '0;
                if (tick_reg >= pird_pkg::SAT_LIMIT)
                begin
                    lock_next = 1'b0;
                    ones_next = '0;
                    bit_next  = '0;
                    byte_next = '0;
                    res_next.pulse_class = pird_pkg::CLS_TIMEOUT;
                end
                else if (ivw <= WW'(cfg.short_min))
                begin
                    res_next.pulse_class = pird_pkg::CLS_TOO_SHORT;
                end
                else if (ivw < WW'(cfg.short_max))
                begin
                    res_next.pulse_class = pird_pkg::CLS_SHORT;
                    if (!cf_reg)
                    begin
                        if (ones_reg < pird_pkg::SAT_LIMIT)
                        begin
                            ones_next = ones_reg + 7'd1;
                        end
                        shift_en  = lock_reg;
                        shift_bit = 1'b1;
                    end
                end
                else if (ivw > WW'(cfg.long_min) && ivw < WW'(cfg.long_max))
                begin
                    res_next.pulse_class = pird_pkg::CLS_LONG;
                    if (!cf_reg)
                    begin
                        // enough preamble ones: a zero locks the framing
                        if (ones_reg > cfg.preamble_min && !lock_reg)
                        begin
                            bit_next  = '0;
                            byte_next = '0;
                            lock_next = 1'b1;
                        end
                        shift_en  = lock_next;
                        shift_bit = 1'b0;
                        ones_next = '0;
                    end
                end
                else
                begin
                    lock_next = 1'b0;
                    ones_next = '0;
                    bit_next  = '0;
                    byte_next = '0;
                    res_next.pulse_class = pird_pkg::CLS_GAP;
                end
            end
            pird_pkg::OP_TICK:
            begin
                if (tick_reg < pird_pkg::SAT_LIMIT)
                begin
                    tick_next = tick_reg + 7'd1;
                end
            end
            pird_pkg::OP_ACK:
            begin
                cf_next = 1'b0;
            end
            pird_pkg::OP_READ:
            begin
                mem_req.rd_en   = idx_w <= KW'(BUF_BYTES);
                mem_req.rd_addr = pird_pkg::MEM_AW_MAX'(idx_w);
            end
            default:
            begin
            end
        endcase

        if (shift_en)
        begin
            shift_next = {shift_reg[6:0], shift_bit};
            if (bit_next == 3'd7)
            begin
                bit_next = '0;
                byte_cur = byte_next;
                // bytes past the end of the buffer are dropped
                if (byte_cur < CW'(BUF_BYTES))
                begin
                    byte_inc                = byte_cur + 1'b1;
                    mem_req.wr_en           = 1'b1;
                    mem_req.wr_addr         = pird_pkg::MEM_AW_MAX'(byte_cur);
                    mem_req.wr_data         = shift_next;
                    res_next.byte_done      = 1'b1;
                    res_next.byte_value     = shift_next;
                    res_next.byte_position  = 3'(byte_cur);
                    if (KW'(byte_inc) >= KW'(cfg.message_len))
                    begin
                        // terminator: invalidate the entry behind the last byte
                        mem_req.clr_en        = 1'b1;
                        mem_req.clr_addr      = pird_pkg::MEM_AW_MAX'(byte_inc);
                        cf_next               = 1'b1;
                        byte_next             = '0;
                        res_next.message_done = 1'b1;
                    end
                    else
                    begin
                        byte_next = byte_inc;
                    end
                end
            end
            else
            begin
                bit_next = bit_next + 3'd1;
            end
        end

        res_next.complete_now = cf_next;
        res_next.locked_now   = lock_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= '0;
            tick_reg  <= '0;
            lock_reg  <= 1'b0;
            ones_reg  <= '0;
            bit_reg   <= '0;
            byte_reg  <= '0;
            shift_reg <= '0;
            cf_reg    <= 1'b0;
        end
        else if (take)
        begin
            last_reg  <= last_next;
            tick_reg  <= tick_next;
            lock_reg  <= lock_next;
            ones_reg  <= ones_next;
            bit_reg   <= bit_next;
            byte_reg  <= byte_next;
            shift_reg <= shift_next;
            cf_reg    <= cf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule

// ===== bench/testbench.sv =====
// self-checking testbench for the pulse interval remote decoder
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_BYTES = 8;
    localparam int TIME_BITS = 16;

    typedef struct packed {
        logic [2:0] pulse_class;
        logic       byte_done;
        logic [7:0] byte_value;
        logic [2:0] byte_position;
        logic       message_done;
        logic       complete_now;
        logic       locked_now;
        logic [7:0] read_data;
    } decode_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [pird_pkg::APB_AW-1:0] paddr;
    logic [pird_pkg::APB_DW-1:0] pwdata;
    logic [pird_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    pird_evt_if #(.TIME_BITS(TIME_BITS)) evt_ch ();
    pird_res_if res_ch ();

    pulse_interval_remote_decoder_top #(
        .BUF_BYTES(BUF_BYTES),
        .TIME_BITS(TIME_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .evt     (evt_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // decoder state as the checker sees it
    pird_pkg::cfg_t cur_cfg;
    logic [15:0]    last_edge;
    int             ticks;
    int             ones;
    int             bit_cnt;
    int             byte_cnt;
    logic           locked;
    logic           done_flag;
    logic [7:0]     shreg;
    logic [7:0]     msg_store [0:BUF_BYTES];
    decode_t        pending_results [$];

    logic [15:0] stim_time;
    int          items_sent;
    int          results_checked;
    int          bytes_seen;
    int          messages_seen;
    int          error_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          stall_left = 0;

    function automatic void clear_framing();
        bit_cnt = 0;
        byte_cnt = 0;
        locked = 1'b0;
        ones = 0;
    endfunction

    function automatic void reset_decoder_state();
        cur_cfg = pird_pkg::CFG_RESET;
        last_edge = '0;
        ticks = 0;
        shreg = '0;
        done_flag = 1'b0;
        clear_framing();
        for (int i = 0; i <= BUF_BYTES; i++)
            msg_store[i] = '0;
    endfunction

    function automatic void shift_in(input logic b, inout decode_t r);
        shreg = {shreg[6:0], b};
        bit_cnt++;
        if (bit_cnt < 8)
            return;
        // bytes past the end of the buffer are dropped
        if (byte_cnt < BUF_BYTES)
        begin
            msg_store[byte_cnt] = shreg;
            r.byte_done = 1'b1;
            r.byte_value = shreg;
            r.byte_position = 3'(byte_cnt);
            byte_cnt++;
            if (byte_cnt >= cur_cfg.message_len)
            begin
                msg_store[byte_cnt] = 8'h00;
                done_flag = 1'b1;
                byte_cnt = 0;
                ticks = 0;
                r.message_done = 1'b1;
            end
        end
        bit_cnt = 0;
    endfunction

    function automatic void predict_decode(input logic [1:0] op, input logic [15:0] cap,
                                           input logic [3:0] idx);
        decode_t     r;
        logic [15:0] gap_len;
        r = '0;
        r.pulse_class = pird_pkg::CLS_NONE;
        case (op)
            pird_pkg::OP_EDGE:
            begin
                if (ticks >= pird_pkg::SAT_LIMIT)
                begin
                    clear_framing();
                    r.pulse_class = pird_pkg::CLS_TIMEOUT;
                end
                else
                begin
                    gap_len = cap - last_edge;
                    if (gap_len <= cur_cfg.short_min)
                        r.pulse_class = pird_pkg::CLS_TOO_SHORT;
                    else if (gap_len < cur_cfg.short_max)
                    begin
                        r.pulse_class = pird_pkg::CLS_SHORT;
                        if (!done_flag)
                        begin
                            if (ones < pird_pkg::SAT_LIMIT)
                                ones++;
                            if (locked)
                                shift_in(1'b1, r);
                        end
                    end
                    else if (gap_len > cur_cfg.long_min && gap_len < cur_cfg.long_max)
                    begin
                        r.pulse_class = pird_pkg::CLS_LONG;
                        if (!done_flag)
                        begin
                            if (ones > cur_cfg.preamble_min && !locked)
                            begin
                                bit_cnt = 0;
                                byte_cnt = 0;
                                locked = 1'b1;
                            end
                            if (locked)
                                shift_in(1'b0, r);
                            ones = 0;
                        end
                    end
                    else
                    begin
                        clear_framing();
                        r.pulse_class = pird_pkg::CLS_GAP;
                    end
                end
                last_edge = cap;
                ticks = 0;
            end
            pird_pkg::OP_TICK:
            begin
                if (ticks < pird_pkg::SAT_LIMIT)
                    ticks++;
            end
            pird_pkg::OP_ACK:
                done_flag = 1'b0;
            default:
            begin
                if (idx <= BUF_BYTES)
                    r.read_data = msg_store[idx];
            end
        endcase
        r.complete_now = done_flag;
        r.locked_now = locked;
        pending_results.push_back(r);
    endfunction

    // result side: random stalls, or a counted hold-off when one is requested
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        decode_t want;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no result pending");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (want.byte_done)
                    bytes_seen++;
                if (want.message_done)
                    messages_seen++;
                check_field("pulse_class", want.pulse_class, res_ch.pulse_class);
                check_field("byte_done", want.byte_done, res_ch.byte_done);
                check_field("byte_value", want.byte_value, res_ch.byte_value);
                check_field("byte_position", want.byte_position, res_ch.byte_position);
                check_field("message_done", want.message_done, res_ch.message_done);
                check_field("complete_now", want.complete_now, res_ch.complete_now);
                check_field("locked_now", want.locked_now, res_ch.locked_now);
                check_field("read_data", want.read_data, res_ch.read_data);
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [15:0] cap,
                             input logic [3:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            evt_ch.valid <= 1'b0;
            @(posedge clk);
        end
        evt_ch.valid <= 1'b1;
        evt_ch.opcode <= op;
        evt_ch.capture_time <= cap;
        evt_ch.read_index <= idx;
        @(posedge clk);
        while (evt_ch.ready !== 1'b1)
            @(posedge clk);
        predict_decode(op, cap, idx);
        if (op == pird_pkg::OP_EDGE)
            stim_time = cap;
        items_sent++;
    endtask

    task automatic send_edge(input logic [15:0] interval);
        send_item(pird_pkg::OP_EDGE, stim_time + interval, 4'($urandom));
    endtask

    task automatic send_op(input logic [1:0] op);
        send_item(op, 16'($urandom), 4'($urandom));
    endtask

    task automatic send_read(input logic [3:0] idx);
        send_item(pird_pkg::OP_READ, 16'($urandom), idx);
    endtask

    // lowers valid and waits until every result has been taken
    task automatic drain();
        evt_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
    endtask

    task automatic apply_config(input pird_pkg::cfg_t c);
        write_reg(pird_pkg::REG_SHORT_MIN, 32'(c.short_min));
        write_reg(pird_pkg::REG_SHORT_MAX, 32'(c.short_max));
        write_reg(pird_pkg::REG_LONG_MIN, 32'(c.long_min));
        write_reg(pird_pkg::REG_LONG_MAX, 32'(c.long_max));
        write_reg(pird_pkg::REG_PREAMBLE_MIN, 32'(c.preamble_min));
        write_reg(pird_pkg::REG_MESSAGE_LEN, 32'(c.message_len));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_cfg = c;
    endtask

    function automatic logic [15:0] short_iv();
        int lo;
        int hi;
        lo = int'(cur_cfg.short_min) + 1;
        hi = int'(cur_cfg.short_max) - 1;
        if (hi < lo)
            return cur_cfg.short_min;
        return 16'($urandom_range(hi, lo));
    endfunction

    function automatic logic [15:0] long_iv();
        int lo;
        int hi;
        lo = int'(cur_cfg.long_min) + 1;
        hi = int'(cur_cfg.long_max) - 1;
        if (hi < lo)
            return cur_cfg.long_min;
        return 16'($urandom_range(hi, lo));
    endfunction

    function automatic logic [15:0] gap_iv();
        if (cur_cfg.long_min >= cur_cfg.short_max && $urandom_range(1) == 1)
            return 16'($urandom_range(cur_cfg.long_min, cur_cfg.short_max));
        return 16'($urandom_range(16'hFFFF, cur_cfg.long_max));
    endfunction

    function automatic logic [15:0] too_short_iv();
        return 16'($urandom_range(cur_cfg.short_min, 0));
    endfunction

    function automatic int preamble_len();
        int n;
        // now and then one too few ones, so the long pulse does not lock
        if ($urandom_range(9) == 0)
            return cur_cfg.preamble_min;
        n = cur_cfg.preamble_min + 1 + $urandom_range(3);
        return (n > 100) ? 100 : n;
    endfunction

    // the locking long pulse already supplies the first bit
    function automatic int frame_bits();
        int nbytes;
        if (cur_cfg.message_len == 0)
            nbytes = 1;
        else if (cur_cfg.message_len > BUF_BYTES)
            nbytes = BUF_BYTES + 1;
        else
            nbytes = cur_cfg.message_len;
        return nbytes * 8 - 1;
    endfunction

    task automatic send_frame(input int n_pre, input int n_bits, input logic clean);
        int roll;
        if ($urandom_range(1) == 1)
            send_edge(gap_iv());
        repeat (n_pre) send_edge(short_iv());
        send_edge(long_iv());
        repeat (n_bits)
        begin
            roll = clean ? 999 : $urandom_range(999);
            if (roll < 3)
                send_edge(gap_iv());
            else if (roll < 8)
                send_edge(too_short_iv());
            else if (roll < 20)
                send_op(pird_pkg::OP_TICK);
            else if (roll < 25)
                send_read(4'($urandom));
            else if ($urandom_range(1) == 1)
                send_edge(short_iv());
            else
                send_edge(long_iv());
        end
    endtask

    function automatic pird_pkg::cfg_t rand_config();
        pird_pkg::cfg_t c;
        c.short_min = 16'($urandom_range(300, 0));
        c.short_max = c.short_min + 16'($urandom_range(400, 2));
        c.long_min = c.short_max + 16'($urandom_range(300, 0));
        c.long_max = c.long_min + 16'($urandom_range(1500, 2));
        c.preamble_min = 7'($urandom_range(12, 0));
        c.message_len = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 0))
                                                  : 4'($urandom_range(8, 1));
        return c;
    endfunction

    task automatic test_interval_windows();
        drain();
        apply_config(pird_pkg::CFG_RESET);
        send_read(4'd0);
        send_read(4'd8);
        send_read(4'd15);
        send_edge(16'd0);
        send_edge(16'd100);
        send_edge(16'd101);
        send_edge(16'd599);
        send_edge(16'd600);
        send_edge(16'd800);
        send_edge(16'd801);
        send_edge(16'd1999);
        send_edge(16'd2000);
        send_item(pird_pkg::OP_EDGE, 16'hFF00, 4'hF);
        // interval measured across the timer wrap
        send_item(pird_pkg::OP_EDGE, 16'h0100, 4'h0);
        send_item(pird_pkg::OP_EDGE, 16'hFFFF, 4'h5);
        send_op(pird_pkg::OP_TICK);
        send_op(pird_pkg::OP_ACK);
        send_read(4'd3);
    endtask

    task automatic test_timeout();
        drain();
        apply_config(pird_pkg::CFG_RESET);
        repeat (99) send_op(pird_pkg::OP_TICK);
        send_edge(short_iv());
        repeat (102) send_op(pird_pkg::OP_TICK);
        send_edge(short_iv());
        repeat (11) send_edge(short_iv());
        send_edge(long_iv());
        // a timeout must also drop the lock
        repeat (100) send_op(pird_pkg::OP_TICK);
        send_edge(long_iv());
    endtask

    task automatic test_config_extremes();
        pird_pkg::cfg_t c;
        c = '{short_min: 16'h0000, short_max: 16'hFFFF, long_min: 16'h0000,
              long_max: 16'hFFFF, preamble_min: 7'd0, message_len: 4'd1};
        drain();
        apply_config(c);
        send_edge(16'd0);
        send_edge(16'd1);
        send_edge(16'hFFFE);
        send_edge(16'hFFFF);
        c = '{short_min: 16'hFFFF, short_max: 16'h0000, long_min: 16'hFFFF,
              long_max: 16'h0000, preamble_min: 7'd99, message_len: 4'd8};
        drain();
        apply_config(c);
        send_edge(16'hFFFF);
        send_edge(16'h1234);
        send_edge(16'd0);
    endtask

    task automatic test_message_lengths();
        pird_pkg::cfg_t c;
        logic [3:0]     lens [4];
        lens = '{4'd0, 4'd1, 4'd8, 4'd15};
        for (int k = 0; k < 4; k++)
        begin
            c = pird_pkg::CFG_RESET;
            c.message_len = lens[k];
            c.preamble_min = (k == 2) ? 7'd99 : 7'd0;
            drain();
            apply_config(c);
            send_frame((k == 2) ? 101 : 1, frame_bits(), 1'b1);
            // pulses while the message waits for its acknowledge take no bits
            send_edge(short_iv());
            send_edge(long_iv());
            for (int i = 0; i < 16; i++)
                send_read(4'(i));
            send_op(pird_pkg::OP_ACK);
        end
    endtask

    task automatic test_backpressure();
        drain();
        apply_config(pird_pkg::CFG_RESET);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        stall_left <= 300;
        send_frame(12, 31, 1'b1);
        send_op(pird_pkg::OP_ACK);
        send_read(4'd0);
    endtask

    task automatic run_traffic(input int n_items);
        int first;
        int roll;
        first = items_sent;
        while (items_sent - first < n_items)
        begin
            roll = $urandom_range(99);
            if (roll < 60)
            begin
                send_frame(preamble_len(), frame_bits(), 1'b0);
                repeat ($urandom_range(3)) send_edge(short_iv());
                repeat ($urandom_range(4, 1)) send_read(4'($urandom));
                if ($urandom_range(9) != 0)
                    send_op(pird_pkg::OP_ACK);
            end
            else if (roll < 75)
                send_item(2'($urandom), 16'($urandom), 4'($urandom));
            else if (roll < 85)
                send_read(4'($urandom));
            else if (roll < 97)
                send_edge(($urandom_range(1) == 1) ? gap_iv() : too_short_iv());
            else
            begin
                repeat ($urandom_range(103, 98)) send_op(pird_pkg::OP_TICK);
                send_edge(short_iv());
            end
        end
    endtask

    task automatic test_random_traffic();
        for (int mode = 0; mode < 4; mode++)
        begin
            drain();
            case (mode)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            apply_config(rand_config());
            run_traffic(70);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        evt_ch.valid = 1'b0;
        evt_ch.opcode = pird_pkg::OP_EDGE;
        evt_ch.capture_time = '0;
        evt_ch.read_index = '0;
        res_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        stim_time = '0;
        items_sent = 0;
        results_checked = 0;
        bytes_seen = 0;
        messages_seen = 0;
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        reset_decoder_state();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_interval_windows();
        test_timeout();
        test_config_extremes();
        test_message_lengths();
        test_backpressure();
        test_random_traffic();

        drain();
        repeat (8) @(posedge clk);
        $display("%0d items sent, %0d results checked, %0d bytes stored, %0d messages completed",
                 items_sent, results_checked, bytes_seen, messages_seen);
        $display("window edges, timeout, register extremes, message lengths, hold-off, idle mixes");
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pird_pkg.sv
rtl/pird_if.sv
rtl/pird_cfg.sv
rtl/pird_store.sv
rtl/pird_core.sv
rtl/pulse_interval_remote_decoder_top.sv
bench/testbench.sv
